// File: src/blae_pkg.sv
// Shared types and constants for the barrier / locker ack engine.
// No dependencies; used by blae_ctrl, blae_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package blae_pkg;

  localparam int TXN_SLOTS    = 64;
  localparam int NUM_BARRIERS = 16;
  localparam int MAX_WAITERS  = 16;
  localparam int COORD_BITS   = 4;

  localparam int SLOT_W = $clog2(TXN_SLOTS);
  localparam int BAR_W  = $clog2(NUM_BARRIERS);
  localparam int WIDX_W = $clog2(MAX_WAITERS);
  localparam int CNT_W  = 5;

  // transaction status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DATA = 2'd1;
  localparam logic [1:0] ST_ACK  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // transaction kinds
  localparam logic [1:0] KIND_NORMAL  = 2'd0;
  localparam logic [1:0] KIND_BARRIER = 2'd2;

  // result kinds
  localparam logic [1:0] RK_DATA = 2'd0;
  localparam logic [1:0] RK_ACK  = 2'd1;
  localparam logic [1:0] RK_DONE = 2'd2;

  // input commands
  localparam logic CMD_REGISTER = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_REG,
    OP_DONE,
    OP_LOCK_ACK,
    OP_BAR_SINGLE,
    OP_BAR_FIRST,
    OP_BAR_JOIN,
    OP_WAIT_RD,
    OP_SRC_RD,
    OP_WAIT_ACK
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_reg;
    logic slot_idle;
    logic done_path;
    logic locker;
    logic bar_present;
    logic cnt_le1;
    logic rel_hit;
    logic last_waiter;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      src;
    logic [15:0]      dst;
    logic [31:0]      rtime;
    logic [CNT_W-1:0] count;
  } txn_rec_t;

endpackage
`default_nettype wire

// File: src/barrier_lock_ack_engine.sv
// Barrier / locker / ack engine: takes register and delivery words, emits data,
// ack and done words. A register or a normal/locker delivery is captured and then
// looked up; a barrier release adds, per acked waiter, the single-port waiter
// memory read followed by the transaction-table read of that waiter and the ack.
// One item is in work at a time; the output word register lets the next item
// be captured while the last result still waits. No clearing pass after reset:
// a valid bit per transaction slot makes unregistered slots read as idle.
// Depends on blae_pkg, blae_ctrl and blae_datapath.
`timescale 1ns / 1ps
`default_nettype none
module barrier_lock_ack_engine (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // trans_id[5:0], barrier_count[10:6], src_addr[26:11], dst_addr[42:27],
  // event_time[74:43], dst_time[106:75], packet_size[122:107]
  input  wire logic [127:0] in_tdata,
  // command[0], kind[2:1]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // start_time[31:0], out_src[47:32], out_dst[63:48], out_size[79:64], out_id[85:80]
  output logic [87:0]       out_tdata,
  // result_kind[1:0]
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  blae_pkg::dp_cmd_t  cmd;
  blae_pkg::dp_stat_t stat;

  blae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  blae_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: src/blae_ctrl.sv
// Controller state machine for the barrier / locker ack engine.
// Depends on blae_pkg; drives blae_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module blae_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire blae_pkg::dp_stat_t stat,
  output blae_pkg::dp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_WREAD = 5'b00100,
    S_SREAD = 5'b01000,
    S_ACKW  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // decode the next step from datapath status
  always_comb begin
    state_nxt = state_r;
    cmd.op    = blae_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = blae_pkg::OP_CAPTURE;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.is_reg) begin
          if (stat.out_free) begin
            cmd.op    = blae_pkg::OP_REG;
            state_nxt = S_IDLE;
          end
        end else if (stat.slot_idle) begin
          state_nxt = S_IDLE;
        end else if (stat.done_path) begin
          if (stat.out_free) begin
            cmd.op    = blae_pkg::OP_DONE;
            state_nxt = S_IDLE;
          end
        end else if (stat.locker) begin
          if (stat.out_free) begin
            cmd.op    = blae_pkg::OP_LOCK_ACK;
            state_nxt = S_IDLE;
          end
        end else if (!stat.bar_present) begin
          if (!stat.cnt_le1) begin
            cmd.op    = blae_pkg::OP_BAR_FIRST;
            state_nxt = S_IDLE;
          end else if (stat.out_free) begin
            cmd.op    = blae_pkg::OP_BAR_SINGLE;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op    = blae_pkg::OP_BAR_JOIN;
          state_nxt = stat.rel_hit ? S_WREAD : S_IDLE;
        end
      end
      S_WREAD: begin
        cmd.op    = blae_pkg::OP_WAIT_RD;
        state_nxt = S_SREAD;
      end
      S_SREAD: begin
        cmd.op    = blae_pkg::OP_SRC_RD;
        state_nxt = S_ACKW;
      end
      S_ACKW: begin
        if (stat.out_free) begin
          cmd.op    = blae_pkg::OP_WAIT_ACK;
          state_nxt = stat.last_waiter ? S_IDLE : S_WREAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/blae_datapath.sv
// Datapath: transaction table, barrier tables, waiter memory, output word register.
// Depends on blae_pkg; commanded by blae_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module blae_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire blae_pkg::dp_cmd_t  cmd,
  output blae_pkg::dp_stat_t      stat,
  input  wire logic [127:0]       in_tdata,
  input  wire logic [2:0]         in_tuser,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [87:0]             out_tdata,
  output logic [1:0]              out_tuser,
  output logic                    out_tlast
);

  localparam int SW = blae_pkg::SLOT_W;
  localparam int BW = blae_pkg::BAR_W;
  localparam int IW = blae_pkg::WIDX_W;
  localparam int CW = blae_pkg::CNT_W;
  localparam logic [CW-1:0] MAXW = CW'(blae_pkg::MAX_WAITERS);

  // captured input word
  logic          cmd_r;
  logic [SW-1:0] slot_r;
  logic [1:0]    kind_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   src_r, dst_r, size_r;
  logic [31:0]   t_r, dt_r;

  // tables
  blae_pkg::txn_rec_t txn_mem [blae_pkg::TXN_SLOTS];
  blae_pkg::txn_rec_t rd_r;
  logic [1:0]    status_mem [blae_pkg::TXN_SLOTS];
  logic [blae_pkg::TXN_SLOTS-1:0] slot_vld_r;
  logic [1:0]    st_rd_r;
  logic          vld_rd_r;
  logic [SW-1:0] wait_mem [blae_pkg::NUM_BARRIERS * blae_pkg::MAX_WAITERS];
  logic [SW-1:0] waiter_r;
  logic          present_r [blae_pkg::NUM_BARRIERS];
  logic [CW-1:0] fill_r [blae_pkg::NUM_BARRIERS];
  logic [CW-1:0] target_r [blae_pkg::NUM_BARRIERS];

  // release walk
  logic [BW-1:0] uid_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] rel_r;

  // output word
  logic          out_valid_r, out_last_r;
  logic [1:0]    out_rk_r;
  logic [31:0]   out_time_r;
  logic [15:0]   out_src_r, out_dst_r, out_size_r;
  logic [SW-1:0] out_id_r;

  logic          out_last_nxt;
  logic [1:0]    out_rk_nxt;
  logic [31:0]   out_time_nxt;
  logic [15:0]   out_src_nxt, out_dst_nxt, out_size_nxt;
  logic [SW-1:0] out_id_nxt;

  logic [SW-1:0] in_slot;
  logic [CW-1:0] in_cnt;
  logic [BW-1:0] uid;
  logic [1:0]    cur_st;
  logic [CW-1:0] fill_cur, fill_new, tgt_new;
  logic          fill_room, rel_hit, out_free, load_out;
  logic [31:0]   lock_time;

  assign in_slot = in_tdata[SW-1:0];
  assign in_cnt  = (in_tdata[10:6] > MAXW) ? MAXW : in_tdata[10:6];

  assign uid       = BW'(rd_r.dst[blae_pkg::COORD_BITS-1:0] % blae_pkg::NUM_BARRIERS);
  assign cur_st    = vld_rd_r ? st_rd_r : blae_pkg::ST_IDLE;
  assign fill_cur  = fill_r[uid];
  assign fill_room = fill_cur < MAXW;
  assign fill_new  = fill_room ? fill_cur + 1'b1 : fill_cur;
  assign tgt_new   = (rd_r.count != '0) ? rd_r.count : target_r[uid];
  assign rel_hit   = fill_new >= tgt_new;
  assign out_free  = !out_valid_r || out_tready;
  assign lock_time = (t_r > rd_r.rtime) ? t_r : rd_r.rtime;

  // status toward the controller
  always_comb begin
    stat.is_reg      = (cmd_r == blae_pkg::CMD_REGISTER);
    stat.slot_idle   = (cur_st == blae_pkg::ST_IDLE);
    stat.done_path   = (cur_st != blae_pkg::ST_DATA) || (rd_r.kind == blae_pkg::KIND_NORMAL);
    stat.locker      = rd_r.kind[0];
    stat.bar_present = present_r[uid];
    stat.cnt_le1     = rd_r.count <= CW'(1);
    stat.rel_hit     = rel_hit;
    stat.last_waiter = (CW'(idx_r) + 1'b1) == rel_r;
    stat.out_free    = out_free;
  end

  // capture input word
  always_ff @(posedge clk) begin
    if (cmd.op == blae_pkg::OP_CAPTURE) begin
      cmd_r  <= in_tuser[0];
      kind_r <= in_tuser[2:1];
      slot_r <= in_slot;
      cnt_r  <= in_cnt;
      src_r  <= in_tdata[26:11];
      dst_r  <= in_tdata[42:27];
      t_r    <= in_tdata[74:43];
      dt_r   <= in_tdata[106:75];
      size_r <= in_tdata[122:107];
    end
  end

  // transaction memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.op == blae_pkg::OP_REG) begin
      txn_mem[slot_r] <= '{kind: kind_r, src: src_r, dst: dst_r, rtime: dt_r, count: cnt_r};
    end
    if (cmd.op == blae_pkg::OP_CAPTURE) begin
      rd_r     <= txn_mem[in_slot];
      st_rd_r  <= status_mem[in_slot];
      vld_rd_r <= slot_vld_r[in_slot];
    end else if (cmd.op == blae_pkg::OP_SRC_RD) begin
      rd_r <= txn_mem[waiter_r];
    end
  end

  // waiter memory
  always_ff @(posedge clk) begin
    if (cmd.op == blae_pkg::OP_BAR_FIRST) begin
      wait_mem[{uid, IW'(0)}] <= slot_r;
    end else if (cmd.op == blae_pkg::OP_BAR_JOIN && fill_room) begin
      wait_mem[{uid, fill_cur[IW-1:0]}] <= slot_r;
    end
    if (cmd.op == blae_pkg::OP_WAIT_RD) begin
      waiter_r <= wait_mem[{uid_r, idx_r}];
    end
  end

  // transaction status memory, one write a cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      blae_pkg::OP_REG:        status_mem[slot_r]   <= blae_pkg::ST_DATA;
      blae_pkg::OP_DONE:       status_mem[slot_r]   <= blae_pkg::ST_DONE;
      blae_pkg::OP_LOCK_ACK,
      blae_pkg::OP_BAR_SINGLE: status_mem[slot_r]   <= blae_pkg::ST_ACK;
      blae_pkg::OP_WAIT_ACK:   status_mem[waiter_r] <= blae_pkg::ST_ACK;
      default: ;
    endcase
  end

  // mark slots that hold a registered transaction; others read as idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (cmd.op == blae_pkg::OP_REG) begin
      slot_vld_r[slot_r] <= 1'b1;
    end
  end

  // barrier tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < blae_pkg::NUM_BARRIERS; i++) begin
        present_r[i] <= 1'b0;
        fill_r[i]    <= '0;
      end
    end else begin
      case (cmd.op)
        blae_pkg::OP_BAR_SINGLE: begin
          if (rd_r.count == CW'(1)) begin
            present_r[uid] <= 1'b1;
            target_r[uid]  <= CW'(1);
            fill_r[uid]    <= '0;
          end
        end
        blae_pkg::OP_BAR_FIRST: begin
          present_r[uid] <= 1'b1;
          target_r[uid]  <= rd_r.count;
          fill_r[uid]    <= CW'(1);
        end
        blae_pkg::OP_BAR_JOIN: begin
          target_r[uid] <= tgt_new;
          fill_r[uid]   <= rel_hit ? '0 : fill_new;
        end
        default: ;
      endcase
    end
  end

  // release walk counters
  always_ff @(posedge clk) begin
    if (cmd.op == blae_pkg::OP_BAR_JOIN) begin
      uid_r <= uid;
      rel_r <= fill_new;
      idx_r <= '0;
    end else if (cmd.op == blae_pkg::OP_WAIT_ACK) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // output word register
  always_comb begin
    load_out = 1'b0;
    case (cmd.op)
      blae_pkg::OP_REG, blae_pkg::OP_DONE, blae_pkg::OP_LOCK_ACK,
      blae_pkg::OP_BAR_SINGLE, blae_pkg::OP_WAIT_ACK: load_out = 1'b1;
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // build the next result word; barrier ack is the default
  always_comb begin
    out_time_nxt = t_r;
    out_id_nxt   = slot_r;
    out_size_nxt = 16'd1;
    out_last_nxt = 1'b1;
    out_rk_nxt   = blae_pkg::RK_ACK;
    out_src_nxt  = '0;
    out_dst_nxt  = rd_r.src;
    case (cmd.op)
      blae_pkg::OP_REG: begin
        out_rk_nxt   = blae_pkg::RK_DATA;
        out_src_nxt  = src_r;
        out_dst_nxt  = (kind_r == blae_pkg::KIND_BARRIER) ? 16'd0 : dst_r;
        out_size_nxt = size_r;
      end
      blae_pkg::OP_DONE: begin
        out_rk_nxt   = blae_pkg::RK_DONE;
        out_src_nxt  = rd_r.src;
        out_dst_nxt  = rd_r.dst;
        out_size_nxt = '0;
      end
      blae_pkg::OP_LOCK_ACK: begin
        out_time_nxt = lock_time;
        out_src_nxt  = rd_r.dst;
        out_dst_nxt  = rd_r.src;
      end
      blae_pkg::OP_WAIT_ACK: begin
        out_id_nxt   = waiter_r;
        out_last_nxt = stat.last_waiter;
      end
      default: ;
    endcase
  end

  // load the result word, hold it otherwise
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_time_r <= out_time_nxt;
      out_id_r   <= out_id_nxt;
      out_size_r <= out_size_nxt;
      out_last_r <= out_last_nxt;
      out_rk_r   <= out_rk_nxt;
      out_src_r  <= out_src_nxt;
      out_dst_r  <= out_dst_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rk_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_id_r, out_size_r, out_dst_r, out_src_r, out_time_r};

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free) else $error("result loaded over a pending word");
  a_reg_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == blae_pkg::OP_REG) |=> (out_valid_r && out_last_r))
    else $error("register result not flagged last");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == blae_pkg::OP_WAIT_ACK) |-> (CW'(idx_r) < rel_r))
    else $error("release walk past waiter count");
`endif

endmodule
`default_nettype wire

// File: sim/barrier_lock_ack_engine_test.sv
// Self-checking bench for barrier_lock_ack_engine: table-driven directed words,
// then random transaction flows checked against a behavioral predictor.
// Depends on blae_pkg and the barrier_lock_ack_engine RTL.
`timescale 1ns / 1ps
module barrier_lock_ack_engine_test;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic        cmd;
    logic [5:0]  id;
    logic [1:0]  kind;
    logic [4:0]  cnt;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] t;
    logic [31:0] dt;
    logic [15:0] size;
  } req_t;

  typedef struct {
    logic [1:0]  rk;
    logic [31:0] t;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] size;
    logic [5:0]  id;
    logic        last;
  } rsp_t;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [127:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [87:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  barrier_lock_ack_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // shadow of the engine's tables
  logic [1:0]  txn_st[blae_pkg::TXN_SLOTS];
  logic [1:0]  txn_kd[blae_pkg::TXN_SLOTS];
  logic [15:0] txn_sa[blae_pkg::TXN_SLOTS];
  logic [15:0] txn_da[blae_pkg::TXN_SLOTS];
  logic [31:0] txn_rt[blae_pkg::TXN_SLOTS];
  logic [4:0]  txn_ct[blae_pkg::TXN_SLOTS];
  bit          bar_live[blae_pkg::NUM_BARRIERS];
  logic [4:0]  bar_goal[blae_pkg::NUM_BARRIERS];
  logic [4:0]  bar_fill[blae_pkg::NUM_BARRIERS];
  logic [5:0]  bar_wait[blae_pkg::NUM_BARRIERS][blae_pkg::MAX_WAITERS];

  rsp_t expected_words[$];
  int   errors;
  int   idle_cycles;
  bit   quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles with no accepted word on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic rsp_t mk(logic [1:0] rk, logic [31:0] t, logic [15:0] s,
                              logic [15:0] d, logic [15:0] sz, logic [5:0] id);
    rsp_t r;
    r.rk = rk; r.t = t; r.src = s; r.dst = d; r.size = sz; r.id = id; r.last = 1'b0;
    return r;
  endfunction

  // work out the words one request causes and advance the shadow tables
  task automatic predict_engine(input req_t q, output rsp_t outs[$]);
    logic [5:0] sl;
    logic [4:0] c;
    logic [3:0] uid;
    logic [31:0] st;
    sl = q.id;
    outs = {};
    if (q.cmd == blae_pkg::CMD_REGISTER) begin
      c = (q.cnt > blae_pkg::MAX_WAITERS) ? 5'(blae_pkg::MAX_WAITERS) : q.cnt;
      txn_st[sl] = blae_pkg::ST_DATA; txn_kd[sl] = q.kind; txn_sa[sl] = q.src;
      txn_da[sl] = q.dst; txn_rt[sl] = q.dt; txn_ct[sl] = c;
      outs.insert(outs.size(), mk(blae_pkg::RK_DATA, q.t, q.src,
                  (q.kind == blae_pkg::KIND_BARRIER) ? 16'd0 : q.dst, q.size, sl));
    end else if (txn_st[sl] == blae_pkg::ST_IDLE) begin
      return;
    end else if (txn_st[sl] != blae_pkg::ST_DATA || txn_kd[sl] == blae_pkg::KIND_NORMAL) begin
      txn_st[sl] = blae_pkg::ST_DONE;
      outs.insert(outs.size(), mk(blae_pkg::RK_DONE, q.t, txn_sa[sl], txn_da[sl], 16'd0, sl));
    end else if (txn_kd[sl][0]) begin
      st = (q.t > txn_rt[sl]) ? q.t : txn_rt[sl];
      outs.insert(outs.size(), mk(blae_pkg::RK_ACK, st, txn_da[sl], txn_sa[sl], 16'd1, sl));
      txn_st[sl] = blae_pkg::ST_ACK;
    end else begin
      uid = txn_da[sl][3:0];
      c = txn_ct[sl];
      if (!bar_live[uid]) begin
        if (c <= 1) begin
          if (c == 1) begin
            bar_live[uid] = 1; bar_goal[uid] = 1; bar_fill[uid] = 0;
          end
          outs.insert(outs.size(), mk(blae_pkg::RK_ACK, q.t, 16'd0, txn_sa[sl], 16'd1, sl));
          txn_st[sl] = blae_pkg::ST_ACK;
        end else begin
          bar_live[uid] = 1; bar_goal[uid] = c; bar_wait[uid][0] = sl; bar_fill[uid] = 1;
        end
      end else begin
        if (bar_fill[uid] < blae_pkg::MAX_WAITERS) begin
          bar_wait[uid][bar_fill[uid]] = sl;
          bar_fill[uid]++;
        end
        if (c > 0) bar_goal[uid] = c;
        if (bar_fill[uid] >= bar_goal[uid]) begin
          for (int i = 0; i < bar_fill[uid] && i < blae_pkg::MAX_WAITERS; i++) begin
            outs.insert(outs.size(), mk(blae_pkg::RK_ACK, q.t, 16'd0,
                        txn_sa[bar_wait[uid][i]], 16'd1, bar_wait[uid][i]));
            txn_st[bar_wait[uid][i]] = blae_pkg::ST_ACK;
          end
          bar_fill[uid] = 0;
        end
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
  endtask

  // drive one request and queue its expected words; a typed row queues its table word
  task automatic send_request(input req_t q, input bit typed, input rsp_t tr);
    rsp_t outs[$];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, q.size, q.dt, q.t, q.dst, q.src, q.cnt, q.id};
    in_tuser <= {q.kind, q.cmd};
    do @(posedge clk); while (!in_tready);
    predict_engine(q, outs);
    if (typed) begin
      tr.last = 1'b1;
      outs = {tr};
    end
    foreach (outs[i]) expected_words.insert(expected_words.size(), outs[i]);
  endtask

  // result side: random stalls, compare field by field
  initial begin
    rsp_t e;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word, id %0d", out_tdata[85:80]);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_tuser !== e.rk) begin
            $error("result_kind exp %0d got %0d", e.rk, out_tuser); errors++;
          end
          if (out_tdata[31:0] !== e.t) begin
            $error("inject_time exp %0h got %0h", e.t, out_tdata[31:0]); errors++;
          end
          if (out_tdata[47:32] !== e.src) begin
            $error("out_src exp %0h got %0h", e.src, out_tdata[47:32]); errors++;
          end
          if (out_tdata[63:48] !== e.dst) begin
            $error("out_dst exp %0h got %0h", e.dst, out_tdata[63:48]); errors++;
          end
          if (out_tdata[79:64] !== e.size) begin
            $error("out_size exp %0h got %0h", e.size, out_tdata[79:64]); errors++;
          end
          if (out_tdata[85:80] !== e.id) begin
            $error("out_id exp %0d got %0d", e.id, out_tdata[85:80]); errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast); errors++;
          end
        end
      end
    end
  end

  function automatic req_t rq(logic cmd, logic [5:0] id, logic [1:0] kd, logic [4:0] cnt,
                              logic [15:0] s, logic [15:0] d, logic [31:0] t,
                              logic [31:0] dt, logic [15:0] sz);
    req_t q;
    q.cmd = cmd; q.id = id; q.kind = kd; q.cnt = cnt; q.src = s; q.dst = d;
    q.t = t; q.dt = dt; q.size = sz;
    return q;
  endfunction

  function automatic req_t rand_req(logic cmd, logic [5:0] id);
    return rq(cmd, id, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 20)),
              16'($urandom), 16'($urandom), $urandom, $urandom,
              16'($urandom_range(1, 65535)));
  endfunction

  // barrier flow: register n members on one barrier id, then deliver each
  task automatic barrier_flow();
    int n;
    logic [3:0] b;
    logic [5:0] ids[$];
    logic [5:0] id;
    req_t q;
    rsp_t none;
    n = $urandom_range(2, 6);
    b = 4'($urandom);
    for (int i = 0; i < n; i++) begin
      id = 6'($urandom);
      ids.insert(ids.size(), id);
      q = rand_req(1'b0, id);
      q.kind = blae_pkg::KIND_BARRIER;
      q.dst[3:0] = b;
      q.cnt = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31)) : 5'(n);
      send_request(q, 0, none);
    end
    foreach (ids[i]) send_request(rand_req(1'b1, ids[i]), 0, none);
  endtask

  dir_row_t dir_rows[$];

  initial begin
    req_t q;
    rsp_t none;
    int sent;
    for (int i = 0; i < blae_pkg::TXN_SLOTS; i++) txn_st[i] = blae_pkg::ST_IDLE;
    for (int i = 0; i < blae_pkg::NUM_BARRIERS; i++) begin
      bar_live[i] = 0; bar_fill[i] = 0;
    end
    errors = 0; idle_cycles = 0; quiet = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    // deliveries to idle slots, extremes, each kind, locker max, barrier cases
    dir_rows = '{
      '{rq(1, 6'd0, 0, 0, 0, 0, 0, 0, 1), 0, none},
      '{rq(0, 6'd0, 0, 0, 16'h0000, 16'h0000, 0, 0, 16'd1), 1,
        mk(blae_pkg::RK_DATA, 0, 0, 0, 1, 0)},
      '{rq(0, 6'd63, 1, 31, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF), 1,
        mk(blae_pkg::RK_DATA, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 63)},
      '{rq(0, 6'd5, 2, 16, 16'h1234, 16'hABCD, 32'd7, 0, 16'd3), 1,
        mk(blae_pkg::RK_DATA, 7, 16'h1234, 0, 3, 5)},
      '{rq(1, 6'd0, 0, 0, 0, 0, 32'd10, 0, 1), 1, mk(blae_pkg::RK_DONE, 10, 0, 0, 0, 0)},
      '{rq(1, 6'd0, 0, 0, 0, 0, 32'd11, 0, 1), 0, none},
      '{rq(1, 6'd63, 0, 0, 0, 0, 32'd5, 0, 1), 0, none},
      '{rq(1, 6'd63, 0, 0, 0, 0, 32'd6, 0, 1), 0, none},
      '{rq(0, 6'd10, 1, 0, 16'h0011, 16'h0022, 32'd100, 32'd50, 16'd4), 0, none},
      '{rq(1, 6'd10, 0, 0, 0, 0, 32'd40, 0, 1), 0, none},
      '{rq(0, 6'd20, 3, 3, 16'h0100, 16'h0203, 32'd1, 32'd9, 16'd2), 0, none},
      '{rq(1, 6'd20, 0, 0, 0, 0, 32'd1, 0, 1), 0, none},
      '{rq(0, 6'd30, 2, 0, 16'h0300, 16'h00F7, 32'd1, 0, 16'd2), 0, none},
      '{rq(1, 6'd30, 0, 0, 0, 0, 32'd2, 0, 1), 0, none},
      '{rq(0, 6'd31, 2, 1, 16'h0301, 16'h0008, 32'd1, 0, 16'd2), 0, none},
      '{rq(1, 6'd31, 0, 0, 0, 0, 32'd3, 0, 1), 0, none},
      '{rq(0, 6'd32, 2, 2, 16'h0302, 16'h0009, 32'd1, 0, 16'd2), 0, none},
      '{rq(0, 6'd33, 2, 0, 16'h0303, 16'h0009, 32'd1, 0, 16'd2), 0, none},
      '{rq(0, 6'd34, 2, 0, 16'h0304, 16'h0009, 32'd1, 0, 16'd2), 0, none},
      '{rq(1, 6'd32, 0, 0, 0, 0, 32'd4, 0, 1), 0, none},
      '{rq(1, 6'd33, 0, 0, 0, 0, 32'd5, 0, 1), 0, none},
      '{rq(0, 6'd32, 0, 0, 16'h0400, 16'h0500, 32'd6, 0, 16'd9), 0, none},
      '{rq(1, 6'd34, 0, 0, 0, 0, 32'd7, 0, 1), 0, none}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    sent = dir_rows.size();
    // random: a quarter barrier flows, a quarter register/deliver groups, half single random words
    while (sent < 470) begin
      if (sent > 400) quiet = 1;
      if (sent > 200 && sent < 215) begin
        in_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: begin
          barrier_flow();
          sent += 8;
        end
        1: begin
          q = rand_req(1'b0, 6'($urandom));
          send_request(q, 0, none);
          send_request(rand_req(1'b1, q.id), 0, none);
          send_request(rand_req(1'b1, q.id), 0, none);
          sent += 3;
        end
        default: begin
          send_request(rand_req(1'($urandom), 6'($urandom)), 0, none);
          sent += 1;
        end
      endcase
    end
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: files.f
src/blae_pkg.sv
src/blae_ctrl.sv
src/blae_datapath.sv
src/barrier_lock_ack_engine.sv
sim/barrier_lock_ack_engine_test.sv
